>>> rtl/pfd_pkg.sv
package pfd_pkg;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int FRAC_W  = 16;
  localparam int ALPHA_W = 17;

  // Multiplier operand A is one bit wider so unsigned coefficients fit as signed.
  localparam int MUL_W   = DATA_W + 1;
  localparam int PROD_W  = MUL_W + DATA_W;
  localparam int WIDE_W  = (PROD_W > ACC_W + 2) ? PROD_W : ACC_W + 2;

  localparam int CFG_W   = (DATA_W > ALPHA_W) ? DATA_W : ALPHA_W;
  localparam int CFG_A_W = 3;

  localparam int IN_W    = ((2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_W   = ((2 * DATA_W + 7) / 8) * 8;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_ALPHA = 3'd2,
    CFG_FILTER_N    = 3'd3,
    CFG_OUT_MAX     = 3'd4,
    CFG_OUT_MIN     = 3'd5,
    CFG_REVERSE_DIR = 3'd6
  } cfg_idx_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic data_t sat_data(input wide_t v);
    logic [WIDE_W-DATA_W:0] top;
    top = v[WIDE_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    else if (v[WIDE_W-1])  return DATA_MIN;
    else                   return DATA_MAX;
  endfunction

  function automatic acc_t sat_acc(input wide_t v);
    logic [WIDE_W-ACC_W:0] top;
    top = v[WIDE_W-1:ACC_W-1];
    if ((&top) || !(|top)) return v[ACC_W-1:0];
    else if (v[WIDE_W-1])  return {1'b1, {(ACC_W-1){1'b0}}};
    else                   return {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

endpackage

>>> rtl/pid_filtered_derivative.sv
// PID controller tick engine, Q16.16, derivative on measurement with a
// first-order filter and a saturating integral.
//
// Input stream s_*: one beat per control tick, carrying the measurement and
// the setpoint. Output stream m_*: one beat per tick, the clamped drive and
// the unsigned-direction error. The user writes gains, filter, clamp limits
// and direction via cfg_we/cfg_addr/cfg_data only while idle (not enforced).
//
// Timing: s_tready is high only in the idle state. After an input beat the
// sequencer runs six steps over one shared 33x32 multiplier (filter factor,
// filter output, alpha, proportional, integral, output), and m_tvalid rises
// when the output step stores the result. It makes four passes through the
// multiplier, with the subtract and sum steps between them, and takes no new
// beat until it is back in idle.
//
// The result sits in an output register; the next beat is taken while it
// waits. If the receiver still holds the previous result when the next one
// is done, the sequencer waits in its last step until m_tready.
//
// Reset (rst, synchronous) clears the filter and integral history, loads the
// register defaults and drops m_tvalid.
module pid_filtered_derivative (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pfd_pkg::IN_W-1:0]      s_tdata,   // measured_val, target_val
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pfd_pkg::OUT_W-1:0]     m_tdata,   // drive_out, raw_error
  input  logic                          cfg_we,
  input  logic [pfd_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [pfd_pkg::CFG_W-1:0]     cfg_data
);
  import pfd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NDM, ST_INNER, ST_DER, ST_PROP, ST_INT, ST_OUT
  } state_t;

  state_t state;

  // configuration
  data_t               prop_gain, integral_gain, out_max, out_min;
  logic [ALPHA_W-1:0]  deriv_alpha;
  logic [DATA_W-2:0]   filter_n;
  logic                reverse_dir;

  // history
  data_t prev_measured, prev_deriv;
  acc_t  integ_acc;

  // per-tick work registers
  data_t meas, dm, err, raw_err, inner, deriv, pterm;
  data_t drive_r, raw_r;
  logic signed [PROD_W-1:0] prod;

  logic signed [MUL_W-1:0]  mul_a;
  data_t                    mul_b;
  logic signed [PROD_W-1:0] mul_p;
  wide_t                    prod_q;

  data_t in_m, in_t;
  wide_t diff, dmeas, total;
  data_t in_raw, in_err, in_dm;
  logic  out_free;

  assign in_m   = s_tdata[DATA_W-1:0];
  assign in_t   = s_tdata[2*DATA_W-1:DATA_W];
  assign diff   = WIDE_W'(in_t) - WIDE_W'(in_m);
  assign dmeas  = WIDE_W'(in_m) - WIDE_W'(prev_measured);
  assign in_raw = sat_data(diff);
  assign in_err = sat_data(reverse_dir ? -diff : diff);
  assign in_dm  = sat_data(dmeas);

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = OUT_W'({raw_r, drive_r});

  always_comb begin
    unique case (state)
      ST_NDM:  begin mul_a = signed'(MUL_W'(filter_n));    mul_b = dm;    end
      ST_DER:  begin mul_a = signed'(MUL_W'(deriv_alpha)); mul_b = inner; end
      ST_PROP: begin mul_a = MUL_W'(prop_gain);            mul_b = err;   end
      ST_INT:  begin mul_a = MUL_W'(integral_gain);        mul_b = err;   end
      default: begin mul_a = '0;                           mul_b = err;   end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  // floor(product / 2^16)
  assign prod_q = WIDE_W'(prod) >>> FRAC_W;
  assign total  = WIDE_W'(deriv) + WIDE_W'(pterm) + WIDE_W'(integ_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      prop_gain     <= '0;
      integral_gain <= '0;
      deriv_alpha   <= '0;
      filter_n      <= (DATA_W-1)'(65536);
      out_max       <= DATA_MAX;
      out_min       <= DATA_MIN;
      reverse_dir   <= 1'b0;
      prev_measured <= '0;
      prev_deriv    <= '0;
      integ_acc     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_PROP_GAIN:   prop_gain     <= cfg_data[DATA_W-1:0];
          CFG_INTEG_GAIN:  integral_gain <= cfg_data[DATA_W-1:0];
          CFG_DERIV_ALPHA: deriv_alpha   <= cfg_data[ALPHA_W-1:0];
          CFG_FILTER_N:    filter_n      <= cfg_data[DATA_W-2:0];
          CFG_OUT_MAX:     out_max       <= cfg_data[DATA_W-1:0];
          CFG_OUT_MIN:     out_min       <= cfg_data[DATA_W-1:0];
          CFG_REVERSE_DIR: reverse_dir   <= cfg_data[0];
          default: ;
        endcase
      end

      // in the last step a departing beat is replaced by the new result
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;

      // hold the last product while waiting on the receiver
      if (state != ST_OUT) prod <= mul_p;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            meas    <= in_m;
            dm      <= in_dm;
            err     <= in_err;
            raw_err <= in_raw;
            state   <= ST_NDM;
          end
        end
        ST_NDM:   state <= ST_INNER;
        ST_INNER: begin
          inner <= sat_data(WIDE_W'(prev_deriv) - WIDE_W'(sat_data(prod_q)));
          state <= ST_DER;
        end
        ST_DER:   state <= ST_PROP;
        ST_PROP: begin
          deriv <= sat_data(prod_q);
          state <= ST_INT;
        end
        ST_INT: begin
          pterm <= sat_data(prod_q);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            if (total > WIDE_W'(out_max))      drive_r <= out_max;
            else if (total < WIDE_W'(out_min)) drive_r <= out_min;
            else                               drive_r <= total[DATA_W-1:0];
            raw_r         <= raw_err;
            integ_acc     <= sat_acc(WIDE_W'(integ_acc) + WIDE_W'(sat_acc(prod_q)));
            prev_deriv    <= deriv;
            prev_measured <= meas;
            m_tvalid      <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pfd_checker.sv
module pfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pfd_pkg::OUT_W-1:0]     m_tdata
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // the sequencer is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a new result only appears at the end of a busy run
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without work in progress");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the output");

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (.*);
